/* design/sgci_pkg.sv */
// Shared types and constants for the staggered grid complex interpolator.
// No dependencies; imported by the corner, blend and top-level modules and referenced by the checker.
package sgci_pkg;

	// Grid geometry and sample format
	localparam int MAX_ROWS     = 64;
	localparam int MAX_COLS     = 64;
	localparam int SAMPLE_WIDTH = 24;
	localparam int ROW_W        = $clog2(MAX_ROWS);
	localparam int COL_W        = $clog2(MAX_COLS);
	localparam int ADDR_W       = ROW_W + COL_W;
	localparam int GRID_DEPTH   = MAX_ROWS * MAX_COLS;
	localparam int CELL_W       = 2 * SAMPLE_WIDTH;

	// Configuration port
	localparam int CNT_W  = 7;
	localparam int PH_W   = 18;
	localparam int CFG_W  = 18;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] CFG_ROWS   = 3'd0;
	localparam logic [IDX_W-1:0] CFG_COLS   = 3'd1;
	localparam logic [IDX_W-1:0] CFG_PH_RE  = 3'd2;
	localparam logic [IDX_W-1:0] CFG_PH_IM  = 3'd3;
	localparam logic [IDX_W-1:0] CFG_IPH_RE = 3'd4;
	localparam logic [IDX_W-1:0] CFG_IPH_IM = 3'd5;

	// Input item opcodes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Datapath widths
	localparam int Q_W      = 16;                 // Q8.8 position
	localparam int OFS_W    = 10;                 // offset from cell center, Q.8
	localparam int CORNER_W = SAMPLE_WIDTH + 4;   // phased corner, Q.20
	localparam int PROD_W   = SAMPLE_WIDTH + PH_W;
	localparam int COEF_W   = 11;                 // blend weights
	localparam int WT_W     = COEF_W + CORNER_W;  // weight times corner
	localparam int INNER_W  = WT_W + 1;
	localparam int SUM4_W   = CORNER_W + 2;
	localparam int S64_W    = SUM4_W + 6;
	localparam int PA_W     = COEF_W + INNER_W;
	localparam int PB_W     = COEF_W + S64_W;
	localparam int TOT_W    = PA_W + 2;
	localparam int RND_W    = TOT_W - 16;

	// Per-stage load enables handed to the datapath slices
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
		logic s8;
	} sgci_en_t;

endpackage

/* design/sgci_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module sgci_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read ports, hold while disabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

/* design/sgci_corner.sv */
// One grid corner: optional complex multiply by the boundary phase with rounding, optional sign flip.
// Depends on sgci_pkg. Stages s3 (products) and s4 (corner value).
module sgci_corner (
	input  logic                                 clk,
	input  sgci_pkg::sgci_en_t                   en,
	input  logic signed [sgci_pkg::SAMPLE_WIDTH-1:0] a,
	input  logic signed [sgci_pkg::SAMPLE_WIDTH-1:0] b,
	input  logic                                 use_ph,
	input  logic                                 neg,
	input  logic signed [sgci_pkg::PH_W-1:0]     pr,
	input  logic signed [sgci_pkg::PH_W-1:0]     pi,
	output logic signed [sgci_pkg::CORNER_W-1:0] re,
	output logic signed [sgci_pkg::CORNER_W-1:0] im
);
	import sgci_pkg::*;

	logic signed [PROD_W-1:0]       p_ar_s3, p_bi_s3, p_ai_s3, p_br_s3;
	logic signed [SAMPLE_WIDTH-1:0] a_s3, b_s3;
	logic                           use_ph_s3, neg_s3;
	logic signed [PROD_W+1:0]       t_re, t_im;
	logic signed [CORNER_W-1:0]     c_re, c_im;

	// Form the four partial products
	always_ff @(posedge clk) begin
		if (en.s3) begin
			p_ar_s3   <= a * pr;
			p_bi_s3   <= b * pi;
			p_ai_s3   <= a * pi;
			p_br_s3   <= b * pr;
			a_s3      <= a;
			b_s3      <= b;
			use_ph_s3 <= use_ph;
			neg_s3    <= neg;
		end
	end

	// Sum and round half up to Q.20 (or pass the sample through), optionally negate
	always_comb begin
		t_re = (PROD_W+2)'(p_ar_s3) - (PROD_W+2)'(p_bi_s3) + (PROD_W+2)'(32768);
		t_im = (PROD_W+2)'(p_ai_s3) + (PROD_W+2)'(p_br_s3) + (PROD_W+2)'(32768);
		if (use_ph_s3) begin
			c_re = t_re[PROD_W+1:16];
			c_im = t_im[PROD_W+1:16];
		end else begin
			c_re = CORNER_W'(a_s3);
			c_im = CORNER_W'(b_s3);
		end
		if (neg_s3) begin
			c_re = -c_re;
			c_im = -c_im;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			re <= c_re;
			im <= c_im;
		end
	end

endmodule

/* design/sgci_blend.sv */
// Quadrant-triangle blend of four corners for one component (re or im).
// Depends on sgci_pkg. Stages s5..s8: weights, inner sum, outer products, round.
module sgci_blend (
	input  logic                                     clk,
	input  sgci_pkg::sgci_en_t                       en,
	input  logic signed [sgci_pkg::OFS_W-1:0]        d,
	input  logic signed [sgci_pkg::OFS_W-1:0]        e,
	input  logic signed [sgci_pkg::CORNER_W-1:0]     sw,
	input  logic signed [sgci_pkg::CORNER_W-1:0]     nw,
	input  logic signed [sgci_pkg::CORNER_W-1:0]     se,
	input  logic signed [sgci_pkg::CORNER_W-1:0]     ne,
	input  logic                                     oor,
	output logic signed [sgci_pkg::SAMPLE_WIDTH-1:0] value
);
	import sgci_pkg::*;

	logic signed [OFS_W:0]      dpe, dme;
	logic signed [COEF_W-1:0]   a_c, u_c, w1, w2;
	logic signed [CORNER_W-1:0] x_c, y_c;
	logic signed [WT_W-1:0]     m1_s5, m2_s5;
	logic signed [SUM4_W-1:0]   sum4_s5;
	logic signed [COEF_W-1:0]   a_s5, a_s6;
	logic signed [INNER_W-1:0]  inner_s6;
	logic signed [S64_W-1:0]    s64_s6;
	logic signed [PA_W-1:0]     pa_s7;
	logic signed [PB_W-1:0]     pb_s7;
	logic signed [TOT_W-1:0]    tot;
	logic signed [RND_W-1:0]    rnd;
	logic signed [SAMPLE_WIDTH-1:0] sat_v;

	// Pick the triangle: outer weight a, edge pair x/y and their split u
	always_comb begin
		dpe = (OFS_W+1)'(d) + (OFS_W+1)'(e);
		dme = (OFS_W+1)'(d) - (OFS_W+1)'(e);
		if (dpe > 0) begin
			if (dme > 0) begin
				a_c = COEF_W'(d) <<< 1; u_c = COEF_W'(e); x_c = ne; y_c = nw;
			end else begin
				a_c = COEF_W'(e) <<< 1; u_c = COEF_W'(d); x_c = ne; y_c = se;
			end
		end else begin
			if (dme > 0) begin
				a_c = -(COEF_W'(e) <<< 1); u_c = COEF_W'(d); x_c = nw; y_c = sw;
			end else begin
				a_c = -(COEF_W'(d) <<< 1); u_c = COEF_W'(e); x_c = se; y_c = sw;
			end
		end
		w1 = COEF_W'(128) + u_c;
		w2 = COEF_W'(128) - u_c;
	end

	// Edge weights and corner sum
	always_ff @(posedge clk) begin
		if (en.s5) begin
			m1_s5   <= w1 * x_c;
			m2_s5   <= w2 * y_c;
			sum4_s5 <= SUM4_W'(sw) + SUM4_W'(nw) + SUM4_W'(se) + SUM4_W'(ne);
			a_s5    <= a_c;
		end
	end

	// Edge total and scaled center
	always_ff @(posedge clk) begin
		if (en.s6) begin
			inner_s6 <= INNER_W'(m1_s5) + INNER_W'(m2_s5);
			s64_s6   <= S64_W'(sum4_s5) <<< 6;
			a_s6     <= a_s5;
		end
	end

	// Outer products
	always_ff @(posedge clk) begin
		if (en.s7) begin
			pa_s7 <= a_s6 * inner_s6;
			pb_s7 <= (COEF_W'(256) - a_s6) * s64_s6;
		end
	end

	// Round half up, saturate, zero when out of range
	always_comb begin
		tot = TOT_W'(pa_s7) + TOT_W'(pb_s7) + TOT_W'(32768);
		rnd = tot[TOT_W-1:16];
		if (rnd > RND_W'((2 ** (SAMPLE_WIDTH - 1)) - 1)) begin
			sat_v = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end else if (rnd < -RND_W'(2 ** (SAMPLE_WIDTH - 1))) begin
			sat_v = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			sat_v = rnd[SAMPLE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s8) begin
			value <= oor ? '0 : sat_v;
		end
	end

endmodule

/* design/staggered_grid_complex_interpolator.sv */
// Top level of the staggered grid complex interpolator: handshake, config,
// query decode, grid RAMs. Depends on sgci_pkg, sgci_ram, sgci_corner, sgci_blend.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_stall   | func, write_row/col, sample_re/im, query_r/z,
//          |                       | odd_in_r
//  out     | out_valid / out_stall | value_re, value_im, out_of_range
//  cfg     | cfg_wen               | cfg_idx, cfg_wdata
//
// One beat per cycle in while in_stall is low; a query's result passes through the
// eight register stages (decode, RAM read, two corner, four blend).
// A write beat updates the grid as it leaves stage 1 and gives no result.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// collapse and a stalled output holds only the stages that are full behind it.
// Reset clears the valid bits and sets the config registers to their defaults; the grid is not cleared.
module staggered_grid_complex_interpolator (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic                                     func,
	input  logic [5:0]                               write_row,
	input  logic [5:0]                               write_col,
	input  logic signed [sgci_pkg::SAMPLE_WIDTH-1:0] sample_re,
	input  logic signed [sgci_pkg::SAMPLE_WIDTH-1:0] sample_im,
	input  logic signed [sgci_pkg::Q_W-1:0]          query_r,
	input  logic signed [sgci_pkg::Q_W-1:0]          query_z,
	input  logic                                     odd_in_r,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic signed [sgci_pkg::SAMPLE_WIDTH-1:0] value_re,
	output logic signed [sgci_pkg::SAMPLE_WIDTH-1:0] value_im,
	output logic                                     out_of_range,
	input  logic                                     cfg_wen,
	input  logic [sgci_pkg::IDX_W-1:0]               cfg_idx,
	input  logic [sgci_pkg::CFG_W-1:0]               cfg_wdata
);
	import sgci_pkg::*;

	localparam int NSTG = 8;

	// Config registers
	logic [CNT_W-1:0]       rows_q, cols_q;
	logic signed [PH_W-1:0] ph_re_q, ph_im_q, iph_re_q, iph_im_q;

	// Handshake state
	logic [NSTG:1]   v_q;
	logic [NSTG+1:1] rdy;
	sgci_en_t        en;

	// Decode signals
	logic signed [Q_W:0]   qr_x, qz_x, qr_mag, qz_mag;
	logic signed [OFS_W-1:0] rlo_o, zlo_o, rhi_o, zhi_o, rmax_s, cmax_s;
	logic signed [Q_W+1:0] d_full, e_full;
	logic [ROW_W-1:0]      rmax, rlo, rhi;
	logic [COL_W-1:0]      cmax, zlo, zhi;
	logic                  oor_c, wlo_c, whi_c, neg_c;

	// Stage 1
	logic                    q_s1, wlo_s1, whi_s1, neg_s1, oor_s1;
	logic [ADDR_W-1:0]       waddr_s1, a_sw_s1, a_nw_s1, a_se_s1, a_ne_s1;
	logic [CELL_W-1:0]       wdata_s1;
	logic signed [OFS_W-1:0] d_s1, e_s1, d_s2, e_s2, d_s3, e_s3, d_s4, e_s4;
	logic                    wlo_s2, whi_s2, neg_s2;
	logic                    oor_s2, oor_s3, oor_s4, oor_s5, oor_s6, oor_s7, oor_s8;
	logic                    ram_we;

	// Stage 2 RAM data and stage 4 corners
	logic [CELL_W-1:0]          sw_s2, nw_s2, se_s2, ne_s2;
	logic signed [CORNER_W-1:0] sw_re, sw_im, nw_re, nw_im, se_re, se_im, ne_re, ne_im;

	// Config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= CNT_W'(64);
			cols_q   <= CNT_W'(64);
			ph_re_q  <= PH_W'(65536);
			ph_im_q  <= '0;
			iph_re_q <= PH_W'(65536);
			iph_im_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_idx)
				CFG_ROWS:   rows_q   <= cfg_wdata[CNT_W-1:0];
				CFG_COLS:   cols_q   <= cfg_wdata[CNT_W-1:0];
				CFG_PH_RE:  ph_re_q  <= cfg_wdata[PH_W-1:0];
				CFG_PH_IM:  ph_im_q  <= cfg_wdata[PH_W-1:0];
				CFG_IPH_RE: iph_re_q <= cfg_wdata[PH_W-1:0];
				CFG_IPH_IM: iph_im_q <= cfg_wdata[PH_W-1:0];
				default: ;
			endcase
		end
	end

	// Ready chain: a stage loads when empty or its successor moves
	always_comb begin
		rdy[NSTG+1] = !out_stall;
		for (int k = NSTG; k >= 1; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
		en.s2 = rdy[2];
		en.s3 = rdy[3];
		en.s4 = rdy[4];
		en.s5 = rdy[5];
		en.s6 = rdy[6];
		en.s7 = rdy[7];
		en.s8 = rdy[8];
	end

	assign in_stall = !rdy[1];

	// Advance valid bits; write beats drop out after stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[1]) v_q[1] <= in_valid;
			if (rdy[2]) v_q[2] <= v_q[1] && q_s1;
			for (int k = 3; k <= NSTG; k++) begin
				if (rdy[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	// Clamp the in-use counts to grid limits, less one
	always_comb begin
		if (rows_q == '0) rmax = '0;
		else if (rows_q >= CNT_W'(MAX_ROWS)) rmax = ROW_W'(MAX_ROWS - 1);
		else rmax = ROW_W'(rows_q - CNT_W'(1));
		if (cols_q == '0) cmax = '0;
		else if (cols_q >= CNT_W'(MAX_COLS)) cmax = COL_W'(MAX_COLS - 1);
		else cmax = COL_W'(cols_q - CNT_W'(1));
		rmax_s = $signed(OFS_W'(rmax));
		cmax_s = $signed(OFS_W'(cmax));
	end

	// Decode position: truncate toward zero, offsets, wrap and mirror
	always_comb begin
		qr_x   = (Q_W+1)'(query_r);
		qz_x   = (Q_W+1)'(query_z);
		qr_mag = (qr_x < 0) ? -qr_x : qr_x;
		qz_mag = (qz_x < 0) ? -qz_x : qz_x;
		rlo_o  = $signed({1'b0, qr_mag[Q_W:8]});
		zlo_o  = $signed({1'b0, qz_mag[Q_W:8]});
		if (qr_x < 0) rlo_o = -rlo_o;
		if (qz_x < 0) zlo_o = -zlo_o;
		d_full = (Q_W+2)'(qr_x) - $signed({rlo_o, 8'h80});
		e_full = (Q_W+2)'(qz_x) - $signed({zlo_o, 8'h80});
		rhi_o  = rlo_o + OFS_W'(1);
		zhi_o  = zlo_o + OFS_W'(1);

		oor_c = (rlo_o > rmax_s) || (rlo_o < -OFS_W'(1)) ||
		        (zlo_o > cmax_s) || (zlo_o < -OFS_W'(1));

		// Mirror below row zero
		neg_c = (rlo_o < 0) && odd_in_r;
		rlo   = (rlo_o < 0) ? '0 : rlo_o[ROW_W-1:0];
		rhi   = (rhi_o > rmax_s) ? rmax : rhi_o[ROW_W-1:0];

		// Wrap along z
		wlo_c = zlo_o < 0;
		zlo   = wlo_c ? cmax : zlo_o[COL_W-1:0];
		whi_c = zhi_o > cmax_s;
		zhi   = whi_c ? '0 : zhi_o[COL_W-1:0];
	end

	// Stage 1: decoded beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_s1 <= 1'b0;
		end else if (rdy[1]) begin
			q_s1 <= (func == FUNC_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			waddr_s1 <= {write_row[ROW_W-1:0], write_col[COL_W-1:0]};
			wdata_s1 <= {sample_re, sample_im};
			a_sw_s1  <= {rlo, zlo};
			a_nw_s1  <= {rhi, zlo};
			a_se_s1  <= {rlo, zhi};
			a_ne_s1  <= {rhi, zhi};
			d_s1     <= d_full[OFS_W-1:0];
			e_s1     <= e_full[OFS_W-1:0];
			wlo_s1   <= wlo_c;
			whi_s1   <= whi_c;
			neg_s1   <= neg_c;
			oor_s1   <= oor_c;
		end
	end

	// Write the grid once, as the beat leaves stage 1
	assign ram_we = v_q[1] && !q_s1 && rdy[2];

	// Two copies of the grid give four reads per cycle while stage 2 loads
	sgci_ram #(.WIDTH(CELL_W), .DEPTH(GRID_DEPTH)) u_ram_lo (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (waddr_s1),
		.wdata   (wdata_s1),
		.re      (en.s2),
		.raddr_a (a_sw_s1),
		.raddr_b (a_nw_s1),
		.rdata_a (sw_s2),
		.rdata_b (nw_s2)
	);

	sgci_ram #(.WIDTH(CELL_W), .DEPTH(GRID_DEPTH)) u_ram_hi (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (waddr_s1),
		.wdata   (wdata_s1),
		.re      (en.s2),
		.raddr_a (a_se_s1),
		.raddr_b (a_ne_s1),
		.rdata_a (se_s2),
		.rdata_b (ne_s2)
	);

	// Carry side fields alongside the data
	always_ff @(posedge clk) begin
		if (en.s2) begin
			d_s2 <= d_s1; e_s2 <= e_s1; oor_s2 <= oor_s1;
			wlo_s2 <= wlo_s1; whi_s2 <= whi_s1; neg_s2 <= neg_s1;
		end
		if (en.s3) begin d_s3 <= d_s2; e_s3 <= e_s2; oor_s3 <= oor_s2; end
		if (en.s4) begin d_s4 <= d_s3; e_s4 <= e_s3; oor_s4 <= oor_s3; end
		if (en.s5) oor_s5 <= oor_s4;
		if (en.s6) oor_s6 <= oor_s5;
		if (en.s7) oor_s7 <= oor_s6;
		if (en.s8) oor_s8 <= oor_s7;
	end

	// Corners: low column uses the inverse phase, high column the phase
	sgci_corner u_sw (
		.clk (clk), .en (en),
		.a (sw_s2[CELL_W-1:SAMPLE_WIDTH]), .b (sw_s2[SAMPLE_WIDTH-1:0]),
		.use_ph (wlo_s2), .neg (neg_s2), .pr (iph_re_q), .pi (iph_im_q),
		.re (sw_re), .im (sw_im)
	);

	sgci_corner u_nw (
		.clk (clk), .en (en),
		.a (nw_s2[CELL_W-1:SAMPLE_WIDTH]), .b (nw_s2[SAMPLE_WIDTH-1:0]),
		.use_ph (wlo_s2), .neg (1'b0), .pr (iph_re_q), .pi (iph_im_q),
		.re (nw_re), .im (nw_im)
	);

	sgci_corner u_se (
		.clk (clk), .en (en),
		.a (se_s2[CELL_W-1:SAMPLE_WIDTH]), .b (se_s2[SAMPLE_WIDTH-1:0]),
		.use_ph (whi_s2), .neg (neg_s2), .pr (ph_re_q), .pi (ph_im_q),
		.re (se_re), .im (se_im)
	);

	sgci_corner u_ne (
		.clk (clk), .en (en),
		.a (ne_s2[CELL_W-1:SAMPLE_WIDTH]), .b (ne_s2[SAMPLE_WIDTH-1:0]),
		.use_ph (whi_s2), .neg (1'b0), .pr (ph_re_q), .pi (ph_im_q),
		.re (ne_re), .im (ne_im)
	);

	// Blend each component
	sgci_blend u_blend_re (
		.clk (clk), .en (en), .d (d_s4), .e (e_s4),
		.sw (sw_re), .nw (nw_re), .se (se_re), .ne (ne_re),
		.oor (oor_s7), .value (value_re)
	);

	sgci_blend u_blend_im (
		.clk (clk), .en (en), .d (d_s4), .e (e_s4),
		.sw (sw_im), .nw (nw_im), .se (se_im), .ne (ne_im),
		.oor (oor_s7), .value (value_im)
	);

	assign out_valid    = v_q[NSTG];
	assign out_of_range = oor_s8;

endmodule

/* design/sgci_checker.sv */
// Port-level checks for the staggered grid complex interpolator, with bind.
// Depends on sgci_pkg and the top level's port list only.
module sgci_checker (
	input logic                                     clk,
	input logic                                     arst_n,
	input logic                                     out_valid,
	input logic                                     out_stall,
	input logic signed [sgci_pkg::SAMPLE_WIDTH-1:0] value_re,
	input logic signed [sgci_pkg::SAMPLE_WIDTH-1:0] value_im,
	input logic                                     out_of_range
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(value_re) && $stable(value_im) &&
			$stable(out_of_range))
		else $error("stalled result beat changed");

	// An out-of-range query gives a zero value
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> value_re == '0 && value_im == '0)
		else $error("out-of-range result is not zero");

	// An accepted out-of-range beat carries a zero real part
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_of_range |-> value_re == '0)
		else $error("out-of-range accepted beat carries a value");

endmodule

bind staggered_grid_complex_interpolator sgci_checker u_sgci_checker (.*);
